// ----- hw/rtl/lbb_pkg.sv -----
// Package for the LRU byte budget tracker: field widths, register codes,
// back-end states and the structs passed between the modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lbb_pkg;

   localparam int LAYER_W   = 6;
   localparam int EXPERT_W  = 8;
   localparam int BYTES_W   = 40;
   localparam int TOTAL_W   = 48;
   localparam int LCOUNT_W  = 7;
   localparam int ECOUNT_W  = 9;
   localparam int CSR_IDX_W = 3;
   localparam int ENTRY_W   = LAYER_W + EXPERT_W + BYTES_W;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUDGET       = 3'd0,
      CSR_RECLAIM_EN   = 3'd1,
      CSR_PREFETCH_EN  = 3'd2,
      CSR_LAYER_COUNT  = 3'd3,
      CSR_EXPERT_COUNT = 3'd4
   } csr_index_type;

   // Back-end sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PRES,
      ST_SCAN,
      ST_MOVE_WR,
      ST_APPEND,
      ST_EV_RD,
      ST_EV_DO,
      ST_INSERT,
      ST_RECLAIM,
      ST_EMIT_RD,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      logic [TOTAL_W-1:0]  budget;
      logic                reclaim_en;
      logic                prefetch_en;
      logic [LCOUNT_W-1:0] layer_count;
      logic [ECOUNT_W-1:0] expert_count;
   } cfg_type;

   // One classified touch as it travels through the queue.
   typedef struct packed {
      logic                accept;
      logic                prefetch;
      logic [LAYER_W-1:0]  layer;
      logic [EXPERT_W-1:0] expert;
      logic [BYTES_W-1:0]  bytes;
   } touch_type;

   typedef struct packed {
      logic [LAYER_W-1:0]  layer;
      logic [EXPERT_W-1:0] expert;
      logic [BYTES_W-1:0]  bytes;
   } entry_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef struct packed {
      logic                accepted;
      logic                evict_valid;
      logic [LAYER_W-1:0]  evicted_layer;
      logic [EXPERT_W-1:0] evicted_expert;
      logic [BYTES_W-1:0]  evicted_bytes;
      logic [TOTAL_W-1:0]  resident_total;
      logic [TOTAL_W-1:0]  prefetch_total;
      logic [TOTAL_W-1:0]  reclaim_total;
      logic                last;
   } rsp_type;

endpackage
`default_nettype wire

// ----- hw/rtl/lbb_if.sv -----
// Channel interfaces for the touch requests and the eviction results.
// Depends on lbb_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface lbb_req_if import lbb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [LAYER_W-1:0]  layer;
   logic [EXPERT_W-1:0] expert;
   logic [BYTES_W-1:0]  entry_bytes;
   logic                prefetch;

   modport source (output valid, layer, expert, entry_bytes, prefetch, input ready);
   modport sink (input valid, layer, expert, entry_bytes, prefetch, output ready);
endinterface

interface lbb_rsp_if import lbb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                accepted;
   logic                evict_valid;
   logic [LAYER_W-1:0]  evicted_layer;
   logic [EXPERT_W-1:0] evicted_expert;
   logic [BYTES_W-1:0]  evicted_bytes;
   logic [TOTAL_W-1:0]  resident_total;
   logic [TOTAL_W-1:0]  prefetch_total;
   logic [TOTAL_W-1:0]  reclaim_total;
   logic                last;

   modport source (output valid, accepted, evict_valid, evicted_layer, evicted_expert,
                   evicted_bytes, resident_total, prefetch_total, reclaim_total, last,
                   input ready);
   modport sink (input valid, accepted, evict_valid, evicted_layer, evicted_expert,
                 evicted_bytes, resident_total, prefetch_total, reclaim_total, last,
                 output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lbb_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/lbb_queue.sv -----
// Two-entry queue that decouples the request front end from the back end.
// Depends on lbb_pkg for the touch struct.
`timescale 1ns / 1ps
`default_nettype none
module lbb_queue import lbb_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire touch_type push_data,
   input  wire logic      pop,
   output touch_type      head_data,
   output logic           full,
   output logic           empty
);

   touch_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = slot_ff[rd_ptr_ff];
   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);

endmodule
`default_nettype wire

// ----- hw/rtl/lbb_front.sv -----
// Front end: takes request transactions and classifies each touch as recorded
// or skipped before it enters the queue. Depends on lbb_pkg and lbb_if.
`timescale 1ns / 1ps
`default_nettype none
module lbb_front import lbb_pkg::*; #(
   parameter int MAX_LAYERS  = 64,
   parameter int MAX_EXPERTS = 256
) (
   lbb_req_if.sink               req,
   input  wire cfg_type          cfg,
   input  wire back_status_type  status,
   input  wire logic             queue_full,
   output logic                  push,
   output touch_type             push_data
);

   logic layer_ok;
   logic expert_ok;
   logic pf_ok;

   // Range checks against both the configured counts and the fixed maximums.
   always_comb begin
      layer_ok  = ({1'b0, req.layer} < cfg.layer_count) &&
                  (32'(req.layer) < MAX_LAYERS);
      expert_ok = ({1'b0, req.expert} < cfg.expert_count) &&
                  (32'(req.expert) < MAX_EXPERTS);
      pf_ok     = !req.prefetch || cfg.prefetch_en;
   end

   // Nothing is taken while the presence map is being cleared.
   assign req.ready = !queue_full && !status.clearing;
   assign push      = req.valid && req.ready;

   always_comb begin
      push_data.accept   = layer_ok && expert_ok && pf_ok;
      push_data.prefetch = req.prefetch;
      push_data.layer    = req.layer;
      push_data.expert   = req.expert;
      push_data.bytes    = req.entry_bytes;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/lbb_back.sv -----
// Back end: sequences the LRU ring, the presence map, the byte counters and the
// eviction buffer, then emits the results. Depends on lbb_pkg, lbb_if, lbb_ram.
`timescale 1ns / 1ps
`default_nettype none
module lbb_back import lbb_pkg::*; #(
   parameter int MAX_LAYERS    = 64,
   parameter int MAX_EXPERTS   = 256,
   parameter int RING_CAPACITY = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       queue_empty,
   input  wire touch_type  queue_head,
   output logic            pop,
   output back_status_type status,
   lbb_rsp_if.source       rsp
);

   localparam int PD = MAX_LAYERS * MAX_EXPERTS;
   localparam int KW = (PD > 1) ? $clog2(PD) : 1;
   localparam int PW = $clog2(RING_CAPACITY);
   localparam int LW = $clog2(RING_CAPACITY + 1);
   localparam int SW = LW + 1;

   back_state_type     state_ff, state_in;
   touch_type          item_ff, item_in;
   logic [PW-1:0]      head_ff, head_in;
   logic [LW-1:0]      len_ff, len_in;
   logic [LW-1:0]      cnt_ff, cnt_in;
   logic [LW-1:0]      pos_ff, pos_in;
   logic [LW-1:0]      dpos_ff, dpos_in;
   logic               dv_ff, dv_in;
   logic               found_ff, found_in;
   logic               ins_ff, ins_in;
   entry_type          hold_ff, hold_in;
   logic [KW-1:0]      clr_ff, clr_in;
   logic [TOTAL_W-1:0] resident_ff, resident_in;
   logic [TOTAL_W-1:0] prefetched_ff, prefetched_in;
   logic [TOTAL_W-1:0] reclaimed_ff, reclaimed_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // Memory ports.
   logic          ring_we;
   logic [PW-1:0] ring_waddr, ring_raddr;
   entry_type     ring_wdata, ring_rdata;
   logic          pres_we, pres_wdata, pres_rdata;
   logic [KW-1:0] pres_waddr, pres_raddr;
   logic          evb_we;
   logic [PW-1:0] evb_waddr, evb_raddr;
   entry_type     evb_rdata;

   logic [BYTES_W-1:0] ev_bytes;
   logic               out_free;
   logic               emit_last;

   // Presence bit index of a (layer, expert) pair.
   function automatic logic [KW-1:0] key_of(input logic [LAYER_W-1:0] l,
                                            input logic [EXPERT_W-1:0] e);
      return KW'(32'(l) * 32'(MAX_EXPERTS) + 32'(e));
   endfunction

   // Ring slot of a position counted from the oldest entry.
   function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] h,
                                             input logic [LW-1:0] p);
      logic [SW-1:0] sum;
      sum = SW'(h) + SW'(p);
      if (sum >= SW'(RING_CAPACITY)) begin
         sum = sum - SW'(RING_CAPACITY);
      end
      return sum[PW-1:0];
   endfunction

   lbb_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_CAPACITY), .AW(PW)) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   lbb_ram #(.WIDTH(1), .DEPTH(PD), .AW(KW)) u_present (
      .clock   (clock),
      .wr_en   (pres_we),
      .wr_addr (pres_waddr),
      .wr_data (pres_wdata),
      .rd_addr (pres_raddr),
      .rd_data (pres_rdata)
   );

   lbb_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_CAPACITY), .AW(PW)) u_evict_buf (
      .clock   (clock),
      .wr_en   (evb_we),
      .wr_addr (evb_waddr),
      .wr_data (ring_rdata),
      .rd_addr (evb_raddr),
      .rd_data (evb_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign ev_bytes  = ring_rdata.bytes;
   assign emit_last = (cnt_ff == '0) || (pos_ff + 1'b1 == cnt_ff);

   // Next state and datapath control.
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      head_in       = head_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      pos_in        = pos_ff;
      dpos_in       = dpos_ff;
      dv_in         = 1'b0;
      found_in      = found_ff;
      ins_in        = ins_ff;
      hold_in       = hold_ff;
      clr_in        = clr_ff;
      resident_in   = resident_ff;
      prefetched_in = prefetched_ff;
      reclaimed_in  = reclaimed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_in        = rsp_ff;
      pop           = 1'b0;
      ring_we       = 1'b0;
      ring_waddr    = slot_of(head_ff, len_ff);
      ring_wdata    = '{layer: item_ff.layer, expert: item_ff.expert, bytes: item_ff.bytes};
      ring_raddr    = head_ff;
      pres_we       = 1'b0;
      pres_waddr    = clr_ff;
      pres_wdata    = 1'b0;
      pres_raddr    = key_of(queue_head.layer, queue_head.expert);
      evb_we        = 1'b0;
      evb_waddr     = cnt_ff[PW-1:0];
      evb_raddr     = pos_ff[PW-1:0];

      unique case (state_ff)
         // Sweep the presence map to zero after reset.
         ST_CLEAR: begin
            pres_we = 1'b1;
            clr_in  = clr_ff + 1'b1;
            if (32'(clr_ff) == PD - 1) begin
               state_in = ST_IDLE;
            end
         end

         // Take the next touch; the presence read is issued at the same time.
         ST_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               item_in  = queue_head;
               cnt_in   = '0;
               pos_in   = '0;
               found_in = 1'b0;
               ins_in   = 1'b0;
               if (queue_head.accept) begin
                  if (queue_head.prefetch) begin
                     prefetched_in = prefetched_ff + TOTAL_W'(queue_head.bytes);
                  end
                  state_in = ST_PRES;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end

         ST_PRES: begin
            if (pres_rdata && (len_ff != '0)) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_APPEND;
            end
         end

         // Walk the ring oldest first; once the entry is found, every later
         // entry moves down one slot.
         ST_SCAN: begin
            ring_raddr = slot_of(head_ff, pos_ff);
            if (pos_ff < len_ff) begin
               dv_in   = 1'b1;
               dpos_in = pos_ff;
               pos_in  = pos_ff + 1'b1;
            end
            if (dv_ff) begin
               if (found_ff) begin
                  ring_we    = 1'b1;
                  ring_waddr = slot_of(head_ff, dpos_ff - 1'b1);
                  ring_wdata = ring_rdata;
               end else if (ring_rdata.layer == item_ff.layer &&
                            ring_rdata.expert == item_ff.expert) begin
                  found_in = 1'b1;
                  hold_in  = ring_rdata;
               end
            end else if (pos_ff == len_ff) begin
               state_in = found_ff ? ST_MOVE_WR : ST_APPEND;
            end
         end

         // The touched entry becomes the most recent one.
         ST_MOVE_WR: begin
            ring_we    = 1'b1;
            ring_waddr = slot_of(head_ff, len_ff - 1'b1);
            ring_wdata = hold_ff;
            pos_in     = '0;
            state_in   = ST_EMIT_RD;
         end

         ST_APPEND: begin
            if (len_ff == LW'(RING_CAPACITY)) begin
               ins_in   = 1'b1;
               state_in = ST_EV_RD;
            end else begin
               state_in = ST_INSERT;
            end
         end

         ST_EV_RD: begin
            ring_raddr = head_ff;
            state_in   = ST_EV_DO;
         end

         // Release the oldest entry and log it in the eviction buffer.
         ST_EV_DO: begin
            pres_we      = 1'b1;
            pres_waddr   = key_of(ring_rdata.layer, ring_rdata.expert);
            resident_in  = (resident_ff >= TOTAL_W'(ev_bytes)) ?
                           resident_ff - TOTAL_W'(ev_bytes) : '0;
            reclaimed_in = reclaimed_ff + TOTAL_W'(ev_bytes);
            evb_we       = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            head_in      = (32'(head_ff) == RING_CAPACITY - 1) ? '0 : head_ff + 1'b1;
            len_in       = len_ff - 1'b1;
            if (ins_ff) begin
               ins_in   = 1'b0;
               state_in = ST_INSERT;
            end else begin
               state_in = ST_RECLAIM;
            end
         end

         ST_INSERT: begin
            ring_we     = 1'b1;
            len_in      = len_ff + 1'b1;
            resident_in = resident_ff + TOTAL_W'(item_ff.bytes);
            pres_we     = 1'b1;
            pres_waddr  = key_of(item_ff.layer, item_ff.expert);
            pres_wdata  = 1'b1;
            state_in    = ST_RECLAIM;
         end

         // Budget check before each further eviction.
         ST_RECLAIM: begin
            pos_in = '0;
            if (cfg.reclaim_en && (resident_ff > cfg.budget) && (len_ff > LW'(1)) &&
                (cnt_ff < LW'(RING_CAPACITY))) begin
               state_in = ST_EV_RD;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end

         ST_EMIT_RD: begin
            state_in = ST_EMIT;
         end

         // One result per eviction, or a single one if there was none.
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.accepted       = item_ff.accept;
               rsp_in.evict_valid    = (cnt_ff != '0);
               rsp_in.evicted_layer  = (cnt_ff != '0) ? evb_rdata.layer : '0;
               rsp_in.evicted_expert = (cnt_ff != '0) ? evb_rdata.expert : '0;
               rsp_in.evicted_bytes  = (cnt_ff != '0) ? evb_rdata.bytes : '0;
               rsp_in.resident_total = resident_ff;
               rsp_in.prefetch_total = prefetched_ff;
               rsp_in.reclaim_total  = reclaimed_ff;
               rsp_in.last           = emit_last;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in   = pos_ff + 1'b1;
                  state_in = ST_EMIT_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         head_ff       <= '0;
         len_ff        <= '0;
         cnt_ff        <= '0;
         pos_ff        <= '0;
         dv_ff         <= 1'b0;
         found_ff      <= 1'b0;
         ins_ff        <= 1'b0;
         resident_ff   <= '0;
         prefetched_ff <= '0;
         reclaimed_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         head_ff       <= head_in;
         len_ff        <= len_in;
         cnt_ff        <= cnt_in;
         pos_ff        <= pos_in;
         dv_ff         <= dv_in;
         found_ff      <= found_in;
         ins_ff        <= ins_in;
         resident_ff   <= resident_in;
         prefetched_ff <= prefetched_in;
         reclaimed_ff  <= reclaimed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      dpos_ff <= dpos_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign status.clearing = (state_ff == ST_CLEAR);

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.accepted       = rsp_ff.accepted;
   assign rsp.evict_valid    = rsp_ff.evict_valid;
   assign rsp.evicted_layer  = rsp_ff.evicted_layer;
   assign rsp.evicted_expert = rsp_ff.evicted_expert;
   assign rsp.evicted_bytes  = rsp_ff.evicted_bytes;
   assign rsp.resident_total = rsp_ff.resident_total;
   assign rsp.prefetch_total = rsp_ff.prefetch_total;
   assign rsp.reclaim_total  = rsp_ff.reclaim_total;
   assign rsp.last           = rsp_ff.last;

endmodule
`default_nettype wire

// ----- hw/rtl/lru_byte_budget_tracker.sv -----
// LRU byte budget tracker top level: configuration registers, front end,
// queue and back end. Depends on lbb_pkg, lbb_if, lbb_front, lbb_queue, lbb_back.
//
// Usage: each request transaction on req_chan is a touch of one (layer, expert)
// entry. Touches that are out of range, or prefetches while prefetch is off, give
// one result with accepted low. A resident entry is moved to most recent; a new
// one is appended, evicting the oldest when the ring is full and, with reclaim
// on, further oldest entries while resident bytes exceed the budget. Each
// eviction is one result on rsp_chan (or one result when none), last marking
// the end of the touch; totals in every result are those after the touch.
// Timing: the ring scan for a touch of a resident entry reads one entry per cycle
// through the single ring RAM port. A two-entry queue lets requests be taken while
// the back end works, and a stalled result waits in its output register. After
// reset the presence map is cleared with req_chan not ready; configuration writes
// are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
module lru_byte_budget_tracker import lbb_pkg::*; #(
   parameter int MAX_LAYERS    = 64,
   parameter int MAX_EXPERTS   = 256,
   parameter int RING_CAPACITY = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   lbb_req_if.sink                   req_chan,
   lbb_rsp_if.source                 rsp_chan,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TOTAL_W-1:0]   csr_wr_data
);

   cfg_type         cfg_ff, cfg_in;
   back_status_type status;
   logic            push, pop, queue_full, queue_empty;
   touch_type       push_data, queue_head;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_BUDGET:       cfg_in.budget       = csr_wr_data;
            CSR_RECLAIM_EN:   cfg_in.reclaim_en   = csr_wr_data[0];
            CSR_PREFETCH_EN:  cfg_in.prefetch_en  = csr_wr_data[0];
            CSR_LAYER_COUNT:  cfg_in.layer_count  = csr_wr_data[LCOUNT_W-1:0];
            CSR_EXPERT_COUNT: cfg_in.expert_count = csr_wr_data[ECOUNT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.budget       <= TOTAL_W'(48'h1_0000_0000);
         cfg_ff.reclaim_en   <= 1'b1;
         cfg_ff.prefetch_en  <= 1'b1;
         cfg_ff.layer_count  <= LCOUNT_W'(64);
         cfg_ff.expert_count <= ECOUNT_W'(256);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lbb_front #(.MAX_LAYERS(MAX_LAYERS), .MAX_EXPERTS(MAX_EXPERTS)) u_front (
      .req        (req_chan),
      .cfg        (cfg_ff),
      .status     (status),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   lbb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (queue_head),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   lbb_back #(
      .MAX_LAYERS    (MAX_LAYERS),
      .MAX_EXPERTS   (MAX_EXPERTS),
      .RING_CAPACITY (RING_CAPACITY)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .queue_head  (queue_head),
      .pop         (pop),
      .status      (status),
      .rsp         (rsp_chan)
   );

endmodule
`default_nettype wire

// ----- tb/sv/lru_byte_budget_tracker_tb.sv -----
// Self-checking testbench for the LRU byte budget tracker: touches are driven on
// the request channel and every eviction result is checked against a predictor.
// Depends on lbb_pkg, lbb_if and the lru_byte_budget_tracker RTL.
`timescale 1ns / 1ps
`default_nettype none
module lru_byte_budget_tracker_tb;
   import lbb_pkg::*;

   localparam int NUM_LAYERS        = 64;
   localparam int EXPERTS_PER_LAYER = 256;
   localparam int RING_SLOTS        = 64;
   localparam logic [TOTAL_W-1:0] TOTAL_MASK = {TOTAL_W{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TOTAL_W-1:0] csr_wr_data = '0;

   lbb_req_if req_chan ();
   lbb_rsp_if rsp_chan ();

   lru_byte_budget_tracker dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state: configuration, ring, presence bits and the counters.
   logic [TOTAL_W-1:0]  cfg_budget;
   logic                cfg_reclaim;
   logic                cfg_prefetch;
   logic [LCOUNT_W-1:0] cfg_layers;
   logic [ECOUNT_W-1:0] cfg_experts;
   entry_type           ring [RING_SLOTS];
   int                  ring_head;
   int                  ring_len;
   bit                  present [NUM_LAYERS*EXPERTS_PER_LAYER];
   logic [TOTAL_W-1:0]  resident;
   logic [TOTAL_W-1:0]  prefetched;
   logic [TOTAL_W-1:0]  reclaimed;

   rsp_type expected_evictions [$];
   int      error_count = 0;
   int      send_gap_max = 17;
   int      recv_gap_max = 17;
   bit      recv_hold = 1'b0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Remove the oldest ring entry and release its bytes.
   function automatic entry_type pop_oldest();
      entry_type e;
      e = ring[ring_head];
      ring_head = (ring_head + 1) % RING_SLOTS;
      ring_len--;
      present[e.layer * EXPERTS_PER_LAYER + e.expert] = 1'b0;
      resident = (resident >= TOTAL_W'(e.bytes)) ? resident - TOTAL_W'(e.bytes) : '0;
      reclaimed = (reclaimed + TOTAL_W'(e.bytes)) & TOTAL_MASK;
      return e;
   endfunction

   // Work out the results one touch produces and queue them.
   function automatic void predict_touch(input logic [LAYER_W-1:0] layer,
                                         input logic [EXPERT_W-1:0] expert,
                                         input logic [BYTES_W-1:0] nbytes,
                                         input logic pf);
      entry_type evicted [$];
      entry_type held;
      rsp_type   r;
      bit        accept;
      bit        moved;
      int        key;
      int        s;
      accept = (layer < cfg_layers) && (expert < cfg_experts) && !(pf && !cfg_prefetch);
      moved = 1'b0;
      key = layer * EXPERTS_PER_LAYER + expert;
      if (accept) begin
         if (pf) prefetched = (prefetched + TOTAL_W'(nbytes)) & TOTAL_MASK;
         if (present[key]) begin
            for (int i = 0; i < ring_len && !moved; i++) begin
               s = (ring_head + i) % RING_SLOTS;
               if (ring[s].layer == layer && ring[s].expert == expert) begin
                  held = ring[s];
                  for (int j = i; j + 1 < ring_len; j++)
                     ring[(ring_head + j) % RING_SLOTS] = ring[(ring_head + j + 1) % RING_SLOTS];
                  ring[(ring_head + ring_len - 1) % RING_SLOTS] = held;
                  moved = 1'b1;
               end
            end
         end
         if (!moved) begin
            if (ring_len >= RING_SLOTS) evicted.push_back(pop_oldest());
            ring[(ring_head + ring_len) % RING_SLOTS] = '{layer, expert, nbytes};
            ring_len++;
            resident = (resident + TOTAL_W'(nbytes)) & TOTAL_MASK;
            present[key] = 1'b1;
            while (cfg_reclaim && resident > cfg_budget && ring_len > 1 &&
                   evicted.size() < RING_SLOTS)
               evicted.push_back(pop_oldest());
         end
      end
      r = '0;
      r.accepted = accept;
      r.resident_total = resident;
      r.prefetch_total = prefetched;
      r.reclaim_total = reclaimed;
      if (evicted.size() == 0) begin
         r.last = 1'b1;
         expected_evictions.push_back(r);
      end else begin
         foreach (evicted[k]) begin
            r.evict_valid = 1'b1;
            r.evicted_layer = evicted[k].layer;
            r.evicted_expert = evicted[k].expert;
            r.evicted_bytes = evicted[k].bytes;
            r.last = (k == evicted.size() - 1);
            expected_evictions.push_back(r);
         end
      end
   endfunction

   // Send one touch; the prediction is made when the transaction is taken.
   // Valid stays high into a back-to-back touch and is dropped only for a gap.
   task automatic send_touch(input logic [LAYER_W-1:0] layer,
                             input logic [EXPERT_W-1:0] expert,
                             input logic [BYTES_W-1:0] nbytes, input logic pf);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.layer <= layer;
      req_chan.expert <= expert;
      req_chan.entry_bytes <= nbytes;
      req_chan.prefetch <= pf;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_touch(layer, expert, nbytes, pf);
      @(negedge clock);
   endtask

   // Stop offering, wait until every expected result has come, then settle.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (expected_evictions.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [TOTAL_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_BUDGET:       cfg_budget = value;
         CSR_RECLAIM_EN:   cfg_reclaim = value[0];
         CSR_PREFETCH_EN:  cfg_prefetch = value[0];
         CSR_LAYER_COUNT:  cfg_layers = value[LCOUNT_W-1:0];
         CSR_EXPERT_COUNT: cfg_experts = value[ECOUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [TOTAL_W-1:0] budget, input logic reclaim,
                            input logic pf, input int layers, input int experts);
      drain_results();
      write_register(CSR_BUDGET, budget);
      write_register(CSR_RECLAIM_EN, TOTAL_W'(reclaim));
      write_register(CSR_PREFETCH_EN, TOTAL_W'(pf));
      write_register(CSR_LAYER_COUNT, TOTAL_W'(layers));
      write_register(CSR_EXPERT_COUNT, TOTAL_W'(experts));
   endtask

   function automatic logic [BYTES_W-1:0] random_bytes();
      case ($urandom_range(0, 3))
         0: return BYTES_W'($urandom_range(0, 4096));
         1: return BYTES_W'({$urandom, $urandom});
         2: return {BYTES_W{1'b1}};
         default: return BYTES_W'({$urandom_range(0, 255), $urandom});
      endcase
   endfunction

   // Random touch, mostly drawn from a small working set so hits and moves happen.
   task automatic random_touch(input int set_size);
      logic [LAYER_W-1:0]  layer;
      logic [EXPERT_W-1:0] expert;
      if ($urandom_range(0, 9) == 0) begin
         layer = LAYER_W'($urandom);
         expert = EXPERT_W'($urandom);
      end else begin
         layer = LAYER_W'($urandom_range(0, set_size % 8));
         expert = EXPERT_W'($urandom_range(0, set_size));
      end
      send_touch(layer, expert, random_bytes(), $urandom_range(0, 3) == 0);
   endtask

   // Extremes of the fields, both skip cases and a hit on a resident entry.
   task automatic test_directed();
      send_touch(0, 0, 0, 1'b0);
      send_touch(63, 255, {BYTES_W{1'b1}}, 1'b0);
      send_touch(0, 0, 40'd5, 1'b1);
      send_touch(1, 2, 40'h12345, 1'b0);
      send_touch(1, 2, 40'h99, 1'b1);
      send_touch(0, 0, 40'd7, 1'b0);
      send_touch(63, 255, 40'd3, 1'b0);
      configure(48'd100, 1'b1, 1'b0, 10, 20);
      send_touch(10, 0, 40'd1, 1'b0);
      send_touch(0, 20, 40'd1, 1'b0);
      send_touch(3, 3, 40'd1, 1'b1);
      send_touch(3, 3, 40'd60, 1'b0);
      send_touch(4, 4, 40'd60, 1'b0);
      send_touch(5, 5, 40'd200, 1'b0);
      configure(48'd0, 1'b1, 1'b1, 0, 256);
      send_touch(0, 0, 40'd1, 1'b0);
      configure(48'd0, 1'b1, 1'b1, 64, 0);
      send_touch(0, 0, 40'd1, 1'b0);
      configure(48'd0, 1'b1, 1'b1, 127, 511);
      send_touch(7, 7, 40'd2, 1'b0);
      send_touch(8, 8, 40'd2, 1'b0);
   endtask

   // Reclaim off: fill the ring past capacity so the oldest is pushed out.
   task automatic test_ring_overflow();
      configure(TOTAL_MASK, 1'b0, 1'b1, 64, 256);
      for (int i = 0; i < 80; i++)
         send_touch(LAYER_W'(i % 64), EXPERT_W'(i), BYTES_W'($urandom_range(1, 1000)),
                    1'($urandom_range(0, 1)));
      for (int i = 0; i < 20; i++) random_touch(90);
   endtask

   // Large budget then a tiny one: one touch reclaims many entries at once.
   task automatic test_mass_reclaim();
      configure(TOTAL_MASK, 1'b0, 1'b1, 64, 256);
      for (int i = 0; i < 64; i++) send_touch(2, EXPERT_W'(i), 40'd1000, 1'b0);
      configure(48'd1, 1'b1, 1'b1, 64, 256);
      send_touch(9, 9, 40'd1000, 1'b0);
   endtask

   // Receiver holds off for a long stretch while touches keep arriving.
   task automatic test_backpressure();
      configure(48'd20000, 1'b1, 1'b1, 64, 256);
      recv_hold = 1'b1;
      send_gap_max = 0;
      for (int i = 0; i < 30; i++) random_touch(30);
      recv_hold = 1'b0;
      send_gap_max = 17;
      drain_results();
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 80 == 79)
            configure(TOTAL_W'({$urandom_range(0, 65535), $urandom}),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 70), $urandom_range(0, 260));
         if (i % 50 == 25) begin
            send_gap_max = 0;
            recv_gap_max = 0;
         end else if (i % 50 == 0) begin
            send_gap_max = 17;
            recv_gap_max = 17;
         end
         random_touch($urandom_range(4, 120));
      end
   endtask

   // Result checker: each accepted result against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (rsp_chan.valid && rsp_chan.ready) begin
         if (expected_evictions.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_chan.evicted_bytes), 64'd0);
         end else begin
            want = expected_evictions.pop_front();
            if (rsp_chan.accepted !== want.accepted)
               report_mismatch("accepted", 64'(rsp_chan.accepted), 64'(want.accepted));
            if (rsp_chan.evict_valid !== want.evict_valid)
               report_mismatch("evict_valid", 64'(rsp_chan.evict_valid), 64'(want.evict_valid));
            if (rsp_chan.evicted_layer !== want.evicted_layer)
               report_mismatch("evicted_layer", 64'(rsp_chan.evicted_layer),
                               64'(want.evicted_layer));
            if (rsp_chan.evicted_expert !== want.evicted_expert)
               report_mismatch("evicted_expert", 64'(rsp_chan.evicted_expert),
                               64'(want.evicted_expert));
            if (rsp_chan.evicted_bytes !== want.evicted_bytes)
               report_mismatch("evicted_bytes", 64'(rsp_chan.evicted_bytes),
                               64'(want.evicted_bytes));
            if (rsp_chan.resident_total !== want.resident_total)
               report_mismatch("resident_total", 64'(rsp_chan.resident_total),
                               64'(want.resident_total));
            if (rsp_chan.prefetch_total !== want.prefetch_total)
               report_mismatch("prefetch_total", 64'(rsp_chan.prefetch_total),
                               64'(want.prefetch_total));
            if (rsp_chan.reclaim_total !== want.reclaim_total)
               report_mismatch("reclaim_total", 64'(rsp_chan.reclaim_total),
                               64'(want.reclaim_total));
            if (rsp_chan.last !== want.last)
               report_mismatch("last", 64'(rsp_chan.last), 64'(want.last));
         end
      end
   end

   // Receiver readiness: random gaps per result, or a long hold when asked.
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (recv_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (400) @(negedge clock);
         end
         gap = $urandom_range(0, recv_gap_max);
         if (gap != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.layer = '0;
      req_chan.expert = '0;
      req_chan.entry_bytes = '0;
      req_chan.prefetch = 1'b0;
      cfg_budget = 48'h1_0000_0000;
      cfg_reclaim = 1'b1;
      cfg_prefetch = 1'b1;
      cfg_layers = 7'd64;
      cfg_experts = 9'd256;
      ring_head = 0;
      ring_len = 0;
      resident = '0;
      prefetched = '0;
      reclaimed = '0;
      foreach (present[i]) present[i] = 1'b0;
      foreach (ring[i]) ring[i] = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_ring_overflow();
      test_mass_reclaim();
      test_backpressure();
      configure(48'h1_0000_0000, 1'b1, 1'b1, 64, 256);
      test_random(270);
      drain_results();
      if (error_count == 0)
         $display("lru_byte_budget_tracker verification clean");
      else
         $display("lru_byte_budget_tracker verification failed");
      $finish;
   end

   // Watchdog: covers the clearing pass and the slowest correct run many times.
   initial begin
      #40ms;
      $display("lru_byte_budget_tracker verification failed");
      $finish;
   end
endmodule
`default_nettype wire

// ----- filelist.f -----
hw/rtl/lbb_pkg.sv
hw/rtl/lbb_if.sv
hw/rtl/lbb_ram.sv
hw/rtl/lbb_queue.sv
hw/rtl/lbb_front.sv
hw/rtl/lbb_back.sv
hw/rtl/lru_byte_budget_tracker.sv
tb/sv/lru_byte_budget_tracker_tb.sv
